@@ rtl/core/ppp_pkg.sv @@
package ppp_pkg;

	// Item kinds carried in the input tuser field.
	typedef enum logic [1:0] {
		KIND_POSE   = 2'd0,
		KIND_WORLD  = 2'd1,
		KIND_CAMERA = 2'd2,
		KIND_PIXEL  = 2'd3
	} kind_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_FOCAL_X      = 3'd0,
		REG_FOCAL_Y      = 3'd1,
		REG_CENTER_X     = 3'd2,
		REG_CENTER_Y     = 3'd3,
		REG_IMAGE_WIDTH  = 3'd4,
		REG_IMAGE_HEIGHT = 3'd5,
		REG_UNUSED_6     = 3'd6,
		REG_UNUSED_7     = 3'd7
	} reg_index_t;

	localparam int POSE_WORDS = 12;
	localparam int POSE_TRANS = 9;
	localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
	localparam int QBITS = 41;             // quotient bits 40..0, clamp at 2^40
	localparam int DIV_LAT = QBITS + 1;    // setup stage plus one stage per bit
	localparam int FIFO_DEPTH = 4;

	localparam logic [31:0] RST_FOCAL_X = 32'd65536000;
	localparam logic [31:0] RST_FOCAL_Y = 32'd65536000;
	localparam logic [31:0] RST_CENTER_X = 32'd62914560;
	localparam logic [31:0] RST_CENTER_Y = 32'd35389440;
	localparam logic [15:0] RST_WIDTH = 16'd1920;
	localparam logic [15:0] RST_HEIGHT = 16'd1080;

	// Configuration registers as seen by the datapath.
	typedef struct packed {
		logic [31:0] focal_x;
		logic [31:0] focal_y;
		logic [31:0] center_x;
		logic [31:0] center_y;
		logic [15:0] image_width;
		logic [15:0] image_height;
	} cfg_t;

	// Control that follows a job down the divider pipeline.
	typedef struct packed {
		logic  v;
		kind_t kind;
		logic  zero_depth;
		logic  dz_x;
		logic  dz_y;
	} side_t;

	// One job handed from the front to the back.
	typedef struct packed {
		kind_t       kind;
		logic        zero_depth;
		logic        dz_x;
		logic        dz_y;
		logic        neg_x;
		logic        neg_y;
		logic [63:0] num_x;
		logic [63:0] num_y;
		logic [31:0] den_x;
		logic [31:0] den_y;
	} job_t;

	// Saturate a wide signed value to 32 bits.
	function automatic logic [31:0] sat32(input logic signed [43:0] v);
		logic [31:0] r;
		if (v > 44'sh0007FFFFFFF) r = 32'h7FFF_FFFF;
		else if (v < -44'sh00080000000) r = 32'h8000_0000;
		else r = v[31:0];
		return r;
	endfunction

endpackage

@@ rtl/core/ppp_front.sv @@
module ppp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ppp_pkg::kind_t      in_kind,
	input  logic [3:0]          in_pose_index,
	input  logic [31:0]         in_pose_value,
	input  logic [31:0]         in_point_x,
	input  logic [31:0]         in_point_y,
	input  logic [31:0]         in_point_z,
	input  logic [31:0]         in_pixel_u,
	input  logic [31:0]         in_pixel_v,
	input  ppp_pkg::cfg_t       cfg,
	output logic                job_valid,
	input  logic                job_ready,
	output ppp_pkg::job_t       job
);
	import ppp_pkg::*;

	logic en, acc;
	logic [31:0] pose_q [POSE_WORDS];
	logic [31:0] pt [3];

	logic                v_s1, v_s2, v_s3;
	kind_t               kind_s1, kind_s2;
	logic signed [63:0]  prod_s1 [9];
	logic signed [31:0]  tr_s1 [3];
	logic signed [31:0]  p_s1 [3];
	logic signed [33:0]  du_s1, dv_s1, du_s2, dv_s2;
	logic signed [31:0]  c_s2 [3];
	job_t                job_s3;

	// The front moves as a whole whenever its last register can drain.
	assign en = !v_s3 || job_ready;
	assign in_ready = en;
	assign acc = in_valid && en;
	assign job_valid = v_s3;
	assign job = job_s3;

	assign pt[0] = in_point_x;
	assign pt[1] = in_point_y;
	assign pt[2] = in_point_z;

	// Pose store: identity rotation and zero translation after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POSE_WORDS; i++) begin
				pose_q[i] <= (i == 0 || i == 4 || i == 8) ? ONE_Q30 : '0;
			end
		end else if (acc && in_kind == KIND_POSE && in_pose_index < 4'(POSE_WORDS)) begin
			pose_q[in_pose_index] <= in_pose_value;
		end
	end

	// Valid bits of the three front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc && in_kind != KIND_POSE;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: the nine rotation products, translation and pixel offsets.
	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= in_kind;
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s1[r*3+k] <= $signed(pose_q[r*3+k]) * $signed(pt[k]);
				end
				tr_s1[r] <= $signed(pose_q[POSE_TRANS+r]);
				p_s1[r] <= $signed(pt[r]);
			end
			du_s1 <= 34'($signed(in_pixel_u)) - $signed({2'b00, cfg.center_x});
			dv_s1 <= 34'($signed(in_pixel_v)) - $signed({2'b00, cfg.center_y});
		end
	end

	// Stage 2: world rows rounded to Q16.16 with ties up and saturated; other kinds keep the point.
	always_ff @(posedge clk) begin
		logic signed [65:0] sum;
		logic signed [35:0] sh;
		if (en) begin
			kind_s2 <= kind_s1;
			du_s2 <= du_s1;
			dv_s2 <= dv_s1;
			for (int r = 0; r < 3; r++) begin
				sum = 66'(prod_s1[r*3]) + 66'(prod_s1[r*3+1]) + 66'(prod_s1[r*3+2])
					+ (66'(tr_s1[r]) <<< 30) + 66'sd536870912;
				sh = 36'(sum >>> 30);
				if (kind_s1 == KIND_WORLD) c_s2[r] <= $signed(sat32(44'(sh)));
				else c_s2[r] <= p_s1[r];
			end
		end
	end

	// Stage 3: scale points by focal length (pixels take it as the divisor) and split into sign and magnitudes.
	always_ff @(posedge clk) begin
		logic signed [64:0] nx, ny;
		logic signed [49:0] bx, by;
		if (en) begin
			job_s3.kind <= kind_s2;
			if (kind_s2 == KIND_PIXEL) begin
				bx = 50'(du_s2) <<< 16;
				by = 50'(dv_s2) <<< 16;
				job_s3.zero_depth <= 1'b0;
				job_s3.dz_x <= cfg.focal_x == '0;
				job_s3.dz_y <= cfg.focal_y == '0;
				job_s3.neg_x <= bx < 0;
				job_s3.neg_y <= by < 0;
				job_s3.num_x <= 64'(bx < 0 ? -bx : bx);
				job_s3.num_y <= 64'(by < 0 ? -by : by);
				job_s3.den_x <= cfg.focal_x;
				job_s3.den_y <= cfg.focal_y;
			end else begin
				nx = $signed({1'b0, cfg.focal_x}) * 65'(c_s2[0]);
				ny = $signed({1'b0, cfg.focal_y}) * 65'(c_s2[1]);
				job_s3.zero_depth <= c_s2[2] == '0;
				job_s3.dz_x <= 1'b0;
				job_s3.dz_y <= 1'b0;
				job_s3.neg_x <= (nx < 0) != (c_s2[2] < 0);
				job_s3.neg_y <= (ny < 0) != (c_s2[2] < 0);
				job_s3.num_x <= 64'(nx < 0 ? -nx : nx);
				job_s3.num_y <= 64'(ny < 0 ? -ny : ny);
				job_s3.den_x <= c_s2[2] < 0 ? 32'(-c_s2[2]) : 32'(c_s2[2]);
				job_s3.den_y <= c_s2[2] < 0 ? 32'(-c_s2[2]) : 32'(c_s2[2]);
			end
		end
	end

endmodule

@@ rtl/core/ppp_fifo.sv @@
module ppp_fifo #(
	parameter int DEPTH = ppp_pkg::FIFO_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ppp_pkg::job_t wdata,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output ppp_pkg::job_t rdata
);
	import ppp_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	job_t            mem_q [DEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [AW:0]     cnt_q;

	assign full = cnt_q == (AW+1)'(DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rd_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	// Pointers wrap at the depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

@@ rtl/core/ppp_div.sv @@
module ppp_div (
	input  logic                clk,
	input  logic                en,
	input  logic [63:0]         num,
	input  logic [31:0]         den,
	input  logic                neg,
	output logic signed [41:0]  quot
);
	import ppp_pkg::*;

	logic [64:0]       n;
	logic [31:0]       rem_s [DIV_LAT];
	logic [QBITS-1:0]  low_s [DIV_LAT];
	logic [QBITS-1:0]  q_s [DIV_LAT];
	logic [31:0]       den_s [DIV_LAT];
	logic              neg_s [DIV_LAT];
	logic              ovf_s [DIV_LAT];
	logic [QBITS-1:0]  mag;

	// Setup: add half the divisor for rounding and catch huge quotients early.
	assign n = 65'(num) + 65'(den >> 1);
	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= 32'(n[64:QBITS]) >= den;
			rem_s[0] <= (32'(n[64:QBITS]) >= den) ? '0 : 32'(n[64:QBITS]);
			low_s[0] <= n[QBITS-1:0];
			q_s[0] <= '0;
			den_s[0] <= den;
			neg_s[0] <= neg;
		end
	end

	// One restoring step per stage, most significant quotient bit first.
	for (genvar i = 1; i < DIV_LAT; i++) begin : g_step
		logic [32:0] r2;
		logic        ge;
		assign r2 = {rem_s[i-1], low_s[i-1][QBITS-1]};
		assign ge = r2 >= {1'b0, den_s[i-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? 32'(r2 - {1'b0, den_s[i-1]}) : r2[31:0];
				low_s[i] <= low_s[i-1] << 1;
				q_s[i] <= {q_s[i-1][QBITS-2:0], ge};
				den_s[i] <= den_s[i-1];
				neg_s[i] <= neg_s[i-1];
				ovf_s[i] <= ovf_s[i-1];
			end
		end
	end

	// Clamp to 2^40 and apply the sign.
	assign mag = (ovf_s[DIV_LAT-1] || q_s[DIV_LAT-1] > {1'b1, (QBITS-1)'(0)})
		? {1'b1, (QBITS-1)'(0)} : q_s[DIV_LAT-1];
	assign quot = neg_s[DIV_LAT-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

@@ rtl/core/ppp_back.sv @@
module ppp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_pop,
	input  ppp_pkg::job_t job,
	input  ppp_pkg::cfg_t cfg,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [31:0]   out_x,
	output logic [31:0]   out_y,
	output logic          in_image,
	output logic          zero_depth
);
	import ppp_pkg::*;

	logic                en;
	side_t               side_s [DIV_LAT];
	side_t               fin;
	logic signed [41:0]  qx, qy;
	logic signed [43:0]  u, v, lim_x, lim_y;
	logic                out_v_q, in_img_q, zd_q;
	logic [31:0]         x_q, y_q;

	// The back moves whenever the output register is free or being taken.
	assign en = !out_v_q || out_ready;
	assign job_pop = en && job_valid;

	ppp_div u_div_x (.clk(clk), .en(en), .num(job.num_x), .den(job.den_x),
		.neg(job.neg_x), .quot(qx));
	ppp_div u_div_y (.clk(clk), .en(en), .num(job.num_y), .den(job.den_y),
		.neg(job.neg_y), .quot(qy));

	// Control rides alongside the divider stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) side_s[i] <= '0;
		end else if (en) begin
			side_s[0] <= '{v: job_valid, kind: job.kind, zero_depth: job.zero_depth,
				dz_x: job.dz_x, dz_y: job.dz_y};
			for (int i = 1; i < DIV_LAT; i++) side_s[i] <= side_s[i-1];
		end
	end
	assign fin = side_s[DIV_LAT-1];

	// Principal point offset and image bounds.
	assign u = 44'(qx) + $signed({12'd0, cfg.center_x});
	assign v = 44'(qy) + $signed({12'd0, cfg.center_y});
	assign lim_x = $signed({12'd0, cfg.image_width, 16'd0}) - 44'sd65536;
	assign lim_y = $signed({12'd0, cfg.image_height, 16'd0}) - 44'sd65536;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= fin.v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (fin.kind == KIND_PIXEL) begin
				x_q <= fin.dz_x ? '0 : sat32(44'(qx));
				y_q <= fin.dz_y ? '0 : sat32(44'(qy));
				in_img_q <= 1'b1;
				zd_q <= 1'b0;
			end else if (fin.zero_depth) begin
				x_q <= '0;
				y_q <= '0;
				in_img_q <= 1'b0;
				zd_q <= 1'b1;
			end else begin
				x_q <= sat32(u);
				y_q <= sat32(v);
				in_img_q <= u >= 0 && v >= 0 && u <= lim_x && v <= lim_y;
				zd_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_v_q;
	assign out_x = x_q;
	assign out_y = y_q;
	assign in_image = in_img_q;
	assign zero_depth = zd_q;

endmodule

@@ rtl/core/pinhole_point_projector.sv @@
// Pinhole point projector. One beat per clock is accepted while the job queue
// has room and, when the output is not stalled, one result per clock is
// delivered. Kind 0 beats load a pose word and give no result. Kinds 1 to 3
// give one result each. Between an accepted input beat and m_tvalid lie three
// front stages (rotation products, rounded camera coordinates, focal scaling),
// the small job queue, two bit-per-stage dividers of 42 stages (one per axis)
// and the output register. The dividers set the latency; the rate is one item
// per clock while the output is not stalled. The user must write configuration
// only while no beat is in flight; the block itself does not enforce this.
module pinhole_point_projector #(
	parameter int FIFO_DEPTH = ppp_pkg::FIFO_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [199:0] s_tdata,   // pose_index, pose_value, point_x, point_y,
	                                // point_z, pixel_u, pixel_v, zero pad
	input  logic [1:0]   s_tuser,   // kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,   // out_x, out_y
	output logic [1:0]   m_tuser,   // in_image, zero_depth
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	import ppp_pkg::*;

	cfg_t  cfg_q;
	job_t  f_job, q_job;
	logic  f_valid, q_full, q_empty, q_pop;
	logic [31:0] ox, oy;
	logic  oi, oz;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{focal_x: RST_FOCAL_X, focal_y: RST_FOCAL_Y,
				center_x: RST_CENTER_X, center_y: RST_CENTER_Y,
				image_width: RST_WIDTH, image_height: RST_HEIGHT};
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_FOCAL_X:      cfg_q.focal_x <= cfg_data;
				REG_FOCAL_Y:      cfg_q.focal_y <= cfg_data;
				REG_CENTER_X:     cfg_q.center_x <= cfg_data;
				REG_CENTER_Y:     cfg_q.center_y <= cfg_data;
				REG_IMAGE_WIDTH:  cfg_q.image_width <= cfg_data[15:0];
				REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	ppp_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.in_kind(kind_t'(s_tuser)),
		.in_pose_index(s_tdata[3:0]), .in_pose_value(s_tdata[35:4]),
		.in_point_x(s_tdata[67:36]), .in_point_y(s_tdata[99:68]),
		.in_point_z(s_tdata[131:100]),
		.in_pixel_u(s_tdata[163:132]), .in_pixel_v(s_tdata[195:164]),
		.cfg(cfg_q), .job_valid(f_valid), .job_ready(!q_full), .job(f_job)
	);

	ppp_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(f_valid && !q_full), .wdata(f_job), .full(q_full),
		.pop(q_pop), .empty(q_empty), .rdata(q_job)
	);

	ppp_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(!q_empty), .job_pop(q_pop), .job(q_job), .cfg(cfg_q),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_x(ox), .out_y(oy), .in_image(oi), .zero_depth(oz)
	);

	assign m_tdata = {oy, ox};
	assign m_tuser = {oz, oi};

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import ppp_pkg::*;

	typedef struct {
		kind_t       kind;
		logic [3:0]  pose_index;
		logic [31:0] pose_value;
		logic [31:0] pt_x;
		logic [31:0] pt_y;
		logic [31:0] pt_z;
		logic [31:0] pix_u;
		logic [31:0] pix_v;
	} beat_t;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic        in_image;
		logic        zero_depth;
	} pixel_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [199:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;
	logic [1:0]   m_tuser;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [31:0]  cfg_data;

	pinhole_point_projector dut (.*);

	// Shadow copy of the camera state.
	logic [31:0] cam_fx, cam_fy, cam_cx, cam_cy;
	logic [15:0] cam_w, cam_h;
	logic [31:0] pose[POSE_WORDS];

	beat_t  pending_beats[$];
	pixel_t expected_pixels[$];
	beat_t  cur_beat;
	logic   took;
	int     beats_queued;
	int     beats_taken;
	int     send_idle_pct;
	int     recv_stall_pct;
	int     errors;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint clamp_s32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Rounded division, ties away from zero, magnitude clamped to 2^40.
	function automatic longint div_nearest(longint n, longint d);
		longint unsigned un, ud, q;
		un = n < 0 ? longint'(-n) : n;
		ud = d < 0 ? longint'(-d) : d;
		q = (un + ud / 2) / ud;
		if (q > 64'd1099511627776) q = 64'd1099511627776;
		return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
	endfunction

	// Camera coordinate of one row: exact dot product plus translation, rounded half up, clamped.
	function automatic longint rigid_row(int row, longint p[3]);
		longint acc_hi, acc_lo, prod, h;
		acc_hi = 0;
		acc_lo = 0;
		for (int k = 0; k < 3; k++) begin
			prod = longint'(signed'(pose[row * 3 + k])) * p[k];
			h = prod >>> 30;
			acc_hi += h;
			acc_lo += prod - (h <<< 30);
		end
		acc_hi += longint'(signed'(pose[POSE_TRANS + row]));
		acc_hi += (acc_lo + 64'sd536870912) >>> 30;
		return clamp_s32(acc_hi);
	endfunction

	// Applies one beat to the shadow state; returns 1 with the pixel if one is due.
	function automatic bit project_beat(beat_t b, output pixel_t r);
		longint p[3], c[3], u, v, du, dv;
		r = '{default: '0};
		if (b.kind == KIND_POSE) begin
			if (b.pose_index < POSE_WORDS) pose[b.pose_index] = b.pose_value;
			return 0;
		end
		if (b.kind == KIND_PIXEL) begin
			du = longint'(signed'(b.pix_u)) - longint'(cam_cx);
			dv = longint'(signed'(b.pix_v)) - longint'(cam_cy);
			u = cam_fx != 0 ? div_nearest(du * 65536, longint'(cam_fx)) : 0;
			v = cam_fy != 0 ? div_nearest(dv * 65536, longint'(cam_fy)) : 0;
			r.x = 32'(clamp_s32(u));
			r.y = 32'(clamp_s32(v));
			r.in_image = 1'b1;
			return 1;
		end
		p[0] = longint'(signed'(b.pt_x));
		p[1] = longint'(signed'(b.pt_y));
		p[2] = longint'(signed'(b.pt_z));
		for (int i = 0; i < 3; i++) c[i] = (b.kind == KIND_WORLD) ? rigid_row(i, p) : p[i];
		if (c[2] == 0) begin
			r.zero_depth = 1'b1;
			return 1;
		end
		u = div_nearest(longint'(cam_fx) * c[0], c[2]) + longint'(cam_cx);
		v = div_nearest(longint'(cam_fy) * c[1], c[2]) + longint'(cam_cy);
		r.in_image = !(u < 0 || v < 0 || u > (longint'(cam_w) - 1) * 65536 ||
			v > (longint'(cam_h) - 1) * 65536);
		r.x = 32'(clamp_s32(u));
		r.y = 32'(clamp_s32(v));
		return 1;
	endfunction

	// Input beat accepted: predict at the same edge.
	always @(posedge clk) begin
		pixel_t r;
		took = s_tvalid && s_tready;
		if (took) begin
			beats_taken++;
			if (project_beat(cur_beat, r)) expected_pixels.push_back(r);
		end
	end

	// Driver: present the next pending beat on the falling edge.
	always @(negedge clk) begin
		if (!s_tvalid || took) begin
			if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				cur_beat = pending_beats.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= cur_beat.kind;
				s_tdata <= {4'd0, cur_beat.pix_v, cur_beat.pix_u, cur_beat.pt_z,
					cur_beat.pt_y, cur_beat.pt_x, cur_beat.pose_value, cur_beat.pose_index};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Monitor: compare each output beat with the oldest predicted pixel.
	always @(posedge clk) begin
		pixel_t e;
		if (m_tvalid && m_tready) begin
			if (expected_pixels.size() == 0) begin
				$error("output beat with nothing expected");
				errors++;
			end else begin
				e = expected_pixels.pop_front();
				if (m_tdata[31:0] !== e.x) begin
					$error("out_x expected %h got %h", e.x, m_tdata[31:0]);
					errors++;
				end
				if (m_tdata[63:32] !== e.y) begin
					$error("out_y expected %h got %h", e.y, m_tdata[63:32]);
					errors++;
				end
				if (m_tuser[0] !== e.in_image) begin
					$error("in_image expected %b got %b", e.in_image, m_tuser[0]);
					errors++;
				end
				if (m_tuser[1] !== e.zero_depth) begin
					$error("zero_depth expected %b got %b", e.zero_depth, m_tuser[1]);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(reg_index_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_FOCAL_X: cam_fx = val;
			REG_FOCAL_Y: cam_fy = val;
			REG_CENTER_X: cam_cx = val;
			REG_CENTER_Y: cam_cy = val;
			REG_IMAGE_WIDTH: cam_w = val[15:0];
			REG_IMAGE_HEIGHT: cam_h = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_beat(kind_t k, logic [3:0] idx, logic [31:0] pv, logic [31:0] x,
			logic [31:0] y, logic [31:0] z, logic [31:0] u, logic [31:0] v);
		beat_t b;
		b.kind = k;
		b.pose_index = idx;
		b.pose_value = pv;
		b.pt_x = x;
		b.pt_y = y;
		b.pt_z = z;
		b.pix_u = u;
		b.pix_v = v;
		pending_beats.push_back(b);
		beats_queued++;
	endtask

	// Mostly modest coordinates so that pixels land near the image.
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(32'h0040_0000) - 32'h0020_0000;
			default: return $urandom_range(32'h0400_0000) - 32'h0200_0000;
		endcase
	endfunction

	function automatic logic [31:0] rand_pose_word(int idx);
		if ($urandom_range(3) == 0) return $urandom;
		if (idx < POSE_TRANS)
			return (idx % 4 == 0 ? ONE_Q30 : 32'd0) + $urandom_range(32'h0800_0000)
				- 32'h0400_0000;
		return $urandom_range(32'h0040_0000) - 32'h0020_0000;
	endfunction

	task automatic queue_random(int n);
		int idx;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0, 1: begin
					idx = ($urandom_range(19) == 0) ? $urandom_range(15) : $urandom_range(11);
					queue_beat(KIND_POSE, 4'(idx), rand_pose_word(idx), $urandom, $urandom,
						$urandom, $urandom, $urandom);
				end
				2, 3, 4: queue_beat(KIND_WORLD, 4'($urandom), $urandom, rand_coord(),
					rand_coord(), ($urandom_range(15) == 0) ? 32'd0 : rand_coord(),
					$urandom, $urandom);
				5, 6, 7: queue_beat(KIND_CAMERA, 4'($urandom), $urandom, rand_coord(),
					rand_coord(), ($urandom_range(15) == 0) ? 32'd0 : rand_coord(),
					$urandom, $urandom);
				default: queue_beat(KIND_PIXEL, 4'($urandom), $urandom, $urandom, $urandom,
					$urandom,
					($urandom_range(1)) ? $urandom : cam_cx + $urandom_range(32'h0100_0000),
					($urandom_range(1)) ? $urandom : cam_cy + $urandom_range(32'h0100_0000));
			endcase
		end
	endtask

	// Let the pipeline drain completely before touching the registers.
	task automatic drain();
		wait (beats_taken == beats_queued && expected_pixels.size() == 0);
		repeat (60) @(posedge clk);
	endtask

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		took = 1'b0;
		beats_queued = 0;
		beats_taken = 0;
		errors = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cam_fx = RST_FOCAL_X;
		cam_fy = RST_FOCAL_Y;
		cam_cx = RST_CENTER_X;
		cam_cy = RST_CENTER_Y;
		cam_w = RST_WIDTH;
		cam_h = RST_HEIGHT;
		foreach (pose[i]) pose[i] = 32'd0;
		pose[0] = ONE_Q30;
		pose[4] = ONE_Q30;
		pose[8] = ONE_Q30;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed beats under the reset camera.
		queue_beat(KIND_CAMERA, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h000A_0000, 0, 0);
		queue_beat(KIND_WORLD, 0, 0, 32'h0002_0000, 32'hFFFE_0000, 32'h0005_0000, 0, 0);
		queue_beat(KIND_CAMERA, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'd0, 0, 0);
		queue_beat(KIND_CAMERA, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'hFFF0_0000, 0, 0);
		queue_beat(KIND_CAMERA, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 0, 0);
		queue_beat(KIND_CAMERA, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
		queue_beat(KIND_PIXEL, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
		queue_beat(KIND_PIXEL, 0, 0, 0, 0, 0, RST_CENTER_X, RST_CENTER_Y);
		queue_beat(KIND_POSE, 4'd15, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
		queue_beat(KIND_POSE, 4'd12, 32'h1234_5678, 0, 0, 0, 0, 0);
		queue_beat(KIND_POSE, 4'd0, 32'h8000_0000, 0, 0, 0, 0, 0);
		queue_beat(KIND_POSE, 4'd4, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
		queue_beat(KIND_POSE, 4'd9, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
		queue_beat(KIND_POSE, 4'd11, 32'h0010_0000, 0, 0, 0, 0, 0);
		queue_beat(KIND_WORLD, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 0, 0);
		queue_beat(KIND_WORLD, 0, 0, 32'h0000_8000, 32'h0000_8000, 32'hFFF0_0000, 0, 0);
		queue_beat(KIND_POSE, 4'd11, 32'hFFF0_0000, 0, 0, 0, 0, 0);
		queue_beat(KIND_WORLD, 0, 0, 32'd0, 32'd0, 32'h0010_0000, 0, 0);
		queue_beat(KIND_POSE, 4'd0, ONE_Q30, 0, 0, 0, 0, 0);
		queue_beat(KIND_POSE, 4'd4, ONE_Q30, 0, 0, 0, 0, 0);
		queue_beat(KIND_POSE, 4'd9, 32'd0, 0, 0, 0, 0, 0);
		queue_beat(KIND_POSE, 4'd11, 32'd0, 0, 0, 0, 0, 0);
		drain();

		// Random phases, most under a new camera, each with one of four idling patterns.
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				1: begin
					write_reg(REG_FOCAL_X, 32'd1);
					write_reg(REG_FOCAL_Y, 32'hFFFF_FFFF);
					write_reg(REG_CENTER_X, 32'd0);
					write_reg(REG_CENTER_Y, 32'hFFFF_FFFF);
					write_reg(REG_IMAGE_WIDTH, 32'd1);
					write_reg(REG_IMAGE_HEIGHT, 32'hFFFF);
				end
				2: begin
					write_reg(REG_FOCAL_X, 32'd0);
					write_reg(REG_FOCAL_Y, 32'd0);
					write_reg(REG_IMAGE_WIDTH, 32'd0);
					write_reg(REG_IMAGE_HEIGHT, 32'd0);
					write_reg(REG_UNUSED_6, 32'hFFFF_FFFF);
					write_reg(REG_UNUSED_7, 32'hFFFF_FFFF);
				end
				3: begin
					write_reg(REG_FOCAL_X, 32'hFFFF_FFFF);
					write_reg(REG_FOCAL_Y, 32'd1);
					write_reg(REG_CENTER_X, 32'hFFFF_FFFF);
					write_reg(REG_CENTER_Y, 32'd0);
					write_reg(REG_IMAGE_WIDTH, 32'hFFFF);
					write_reg(REG_IMAGE_HEIGHT, 32'd1);
				end
				4: begin
					write_reg(REG_FOCAL_X, 32'd20_000_000);
					write_reg(REG_FOCAL_Y, 32'd30_000_000);
					write_reg(REG_CENTER_X, 32'd20_971_520);
					write_reg(REG_CENTER_Y, 32'd15_728_640);
					write_reg(REG_IMAGE_WIDTH, 32'd640);
					write_reg(REG_IMAGE_HEIGHT, 32'd480);
				end
				6: begin
					write_reg(REG_FOCAL_X, $urandom);
					write_reg(REG_FOCAL_Y, $urandom);
					write_reg(REG_CENTER_X, $urandom);
					write_reg(REG_CENTER_Y, $urandom);
					write_reg(REG_IMAGE_WIDTH, $urandom_range(16'hFFFF));
					write_reg(REG_IMAGE_HEIGHT, $urandom_range(16'hFFFF));
				end
				7: begin
					write_reg(REG_FOCAL_X, RST_FOCAL_X);
					write_reg(REG_FOCAL_Y, RST_FOCAL_Y);
					write_reg(REG_CENTER_X, RST_CENTER_X);
					write_reg(REG_CENTER_Y, RST_CENTER_Y);
					write_reg(REG_IMAGE_WIDTH, RST_WIDTH);
					write_reg(REG_IMAGE_HEIGHT, RST_HEIGHT);
				end
				default: ;
			endcase
			case (phase % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 77; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 77; end
				default: begin send_idle_pct = 8; recv_stall_pct = 8; end
			endcase
			queue_random(85);
			drain();
		end

		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
